FILE: hw/rtl/pdt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdt_pkg
// Shared types and constants for the posture debounce tracker.
// ----------------------------------------------------------------------------
package pdt_pkg;

    // Confirmed or per-frame posture
    typedef enum logic [1:0] {
        POSTURE_NONE  = 2'd0,
        POSTURE_STAND = 2'd1,
        POSTURE_SIT   = 2'd2
    } posture_t;

    // Event reported on a confirmed posture change
    typedef enum logic [2:0] {
        EV_NONE          = 3'd0,
        EV_STOOD_UP      = 3'd1,
        EV_SAT_DOWN      = 3'd2,
        EV_ARRIVED_STAND = 3'd3,
        EV_ARRIVED_SIT   = 3'd4,
        EV_LEFT_STAND    = 3'd5,
        EV_LEFT_SIT      = 3'd6
    } event_t;

    // Configuration register indexes
    localparam logic CFG_SIT_THRESHOLD  = 1'b0;
    localparam logic CFG_CONFIRM_FRAMES = 1'b1;

    // Field widths
    localparam int DIST_BITS   = 10;
    localparam int COUNT_BITS  = 4;
    localparam int REPORT_BITS = 32;

    // Reset values and defaults
    localparam logic [DIST_BITS-1:0]  SIT_THRESHOLD_RESET  = 10'd120;
    localparam logic [COUNT_BITS-1:0] CONFIRM_FRAMES_RESET = 4'd2;
    localparam int                    DURATION_BITS_DEF    = 32;

endpackage : pdt_pkg
`default_nettype wire

FILE: hw/rtl/posture_debounce_tracker_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// posture_debounce_tracker_unit
// Classifies presence frames, debounces posture changes and tracks sit time.
// ----------------------------------------------------------------------------
// Takes one frame per clock cycle when the result side keeps up. A frame is
// captured in an input register, and once the result register is free the
// whole update (classification, debounce, event and sit counter) runs as one
// short combinational step into the result register, which presents the
// result. Configuration writes are always ready and must be issued while no
// frame is in flight.
// ----------------------------------------------------------------------------
module posture_debounce_tracker_unit
    import pdt_pkg::*;
#(
    parameter int DURATION_BITS = DURATION_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic                   cfg_index,
    input  wire logic [DIST_BITS-1:0]   cfg_data,

    input  wire logic                   frame_valid,
    output logic                        frame_stall,
    input  wire logic                   presence,
    input  wire logic [DIST_BITS-1:0]   lower_boundary_cm,

    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic [1:0]                  posture,
    output logic [2:0]                  event_code,
    output logic [REPORT_BITS-1:0]      reported_seconds,
    output logic [REPORT_BITS-1:0]      sit_seconds
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Configuration
    logic [DIST_BITS-1:0]   threshold_reg;
    logic [COUNT_BITS-1:0]  confirm_reg;

    // Input stage
    logic                   in_vld_reg;
    logic                   in_presence_reg;
    logic [DIST_BITS-1:0]   in_dist_reg;

    // Tracker state
    posture_t               confirmed_reg, confirmed_next;
    posture_t               candidate_reg, candidate_next;
    logic [COUNT_BITS-1:0]  stable_reg, stable_next;
    logic [DURATION_BITS-1:0] sit_cnt_reg, sit_cnt_next;

    // Result stage
    logic                   res_vld_reg;
    posture_t               res_posture_reg;
    event_t                 res_event_reg;
    logic [REPORT_BITS-1:0] res_reported_reg;
    logic [REPORT_BITS-1:0] res_sit_reg;

    // Handshake and datapath wires
    logic                   frame_take;
    logic                   res_free;
    logic                   advance;
    posture_t               target;
    logic [COUNT_BITS-1:0]  stable_inc;
    logic                   change;
    event_t                 event_next;
    logic                   report_sit;
    logic                   clear_cnt;
    logic [DURATION_BITS-1:0] cnt_kept;
    logic [REPORT_BITS-1:0] reported_next;
    logic [REPORT_BITS-1:0] sit_out_next;

    // Handshake control
    assign cfg_ready   = 1'b1;
    assign res_free    = !res_vld_reg || !result_stall;
    assign advance     = in_vld_reg && res_free;
    assign frame_stall = in_vld_reg && !res_free;
    assign frame_take  = frame_valid && !frame_stall;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= SIT_THRESHOLD_RESET;
            confirm_reg   <= CONFIRM_FRAMES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SIT_THRESHOLD:  threshold_reg <= cfg_data;
                CFG_CONFIRM_FRAMES: confirm_reg   <= cfg_data[COUNT_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // Capture the incoming frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (frame_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            in_presence_reg <= presence;
            in_dist_reg     <= lower_boundary_cm;
        end
    end

    // Classify the frame
    always_comb
    begin
        if (!in_presence_reg)
            target = POSTURE_NONE;
        else if (in_dist_reg >= threshold_reg)
            target = POSTURE_SIT;
        else
            target = POSTURE_STAND;
    end

    // Debounce and pick the event
    always_comb
    begin
        stable_inc     = (stable_reg != COUNT_MAX) ? stable_reg + 1'b1 : stable_reg;
        change         = 1'b0;
        confirmed_next = confirmed_reg;
        candidate_next = candidate_reg;
        stable_next    = stable_reg;
        event_next     = EV_NONE;
        report_sit     = 1'b0;
        clear_cnt      = 1'b0;

        if (target == confirmed_reg)
        begin
            candidate_next = confirmed_reg;
            stable_next    = '0;
        end
        else if (target == candidate_reg)
        begin
            stable_next = stable_inc;
            if (stable_inc >= confirm_reg)
            begin
                change         = 1'b1;
                confirmed_next = target;
                stable_next    = '0;
            end
        end
        else
        begin
            candidate_next = target;
            stable_next    = COUNT_BITS'(1);
        end

        if (change)
        begin
            case ({confirmed_reg, target})
                {POSTURE_SIT, POSTURE_STAND}:
                begin
                    event_next = EV_STOOD_UP;
                    report_sit = 1'b1;
                end
                {POSTURE_STAND, POSTURE_SIT}:
                begin
                    event_next = EV_SAT_DOWN;
                    clear_cnt  = 1'b1;
                end
                {POSTURE_NONE, POSTURE_STAND}:
                begin
                    event_next = EV_ARRIVED_STAND;
                end
                {POSTURE_NONE, POSTURE_SIT}:
                begin
                    event_next = EV_ARRIVED_SIT;
                    clear_cnt  = 1'b1;
                end
                {POSTURE_SIT, POSTURE_NONE}:
                begin
                    event_next = EV_LEFT_SIT;
                    report_sit = 1'b1;
                    clear_cnt  = 1'b1;
                end
                {POSTURE_STAND, POSTURE_NONE}:
                begin
                    event_next = EV_LEFT_STAND;
                    clear_cnt  = 1'b1;
                end
                default:
                begin
                    event_next = EV_NONE;
                end
            endcase
        end
    end

    // Update the sit counter, saturating
    always_comb
    begin
        cnt_kept     = clear_cnt ? '0 : sit_cnt_reg;
        sit_cnt_next = cnt_kept;
        if (confirmed_next == POSTURE_SIT && cnt_kept != '1)
            sit_cnt_next = cnt_kept + 1'b1;
    end

    // Clamp or zero-extend counter values onto the 32-bit result fields
    logic [REPORT_BITS-1:0] cnt_now_32;
    logic [REPORT_BITS-1:0] cnt_next_32;

    generate
        if (DURATION_BITS > REPORT_BITS)
        begin : g_clamp
            assign cnt_now_32  = (|sit_cnt_reg[DURATION_BITS-1:REPORT_BITS]) ?
                                 '1 : sit_cnt_reg[REPORT_BITS-1:0];
            assign cnt_next_32 = (|sit_cnt_next[DURATION_BITS-1:REPORT_BITS]) ?
                                 '1 : sit_cnt_next[REPORT_BITS-1:0];
        end
        else if (DURATION_BITS == REPORT_BITS)
        begin : g_equal
            assign cnt_now_32  = sit_cnt_reg;
            assign cnt_next_32 = sit_cnt_next;
        end
        else
        begin : g_extend
            assign cnt_now_32  = {{(REPORT_BITS-DURATION_BITS){1'b0}}, sit_cnt_reg};
            assign cnt_next_32 = {{(REPORT_BITS-DURATION_BITS){1'b0}}, sit_cnt_next};
        end
    endgenerate

    assign reported_next = report_sit ? cnt_now_32 : '0;
    assign sit_out_next  = cnt_next_32;

    // Advance tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirmed_reg <= POSTURE_NONE;
            candidate_reg <= POSTURE_NONE;
            stable_reg    <= '0;
            sit_cnt_reg   <= '0;
        end
        else if (advance)
        begin
            confirmed_reg <= confirmed_next;
            candidate_reg <= candidate_next;
            stable_reg    <= stable_next;
            sit_cnt_reg   <= sit_cnt_next;
        end
    end

    // Hold the result transaction until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_posture_reg  <= confirmed_next;
            res_event_reg    <= event_next;
            res_reported_reg <= reported_next;
            res_sit_reg      <= sit_out_next;
        end
    end

    assign result_valid     = res_vld_reg;
    assign posture          = res_posture_reg;
    assign event_code       = res_event_reg;
    assign reported_seconds = res_reported_reg;
    assign sit_seconds      = res_sit_reg;

`ifndef NO_ASSERTIONS
    // A pending count always belongs to a candidate other than the confirmed one
    a_stable_cand: assert property (@(posedge clk) disable iff (!rst_n)
        stable_reg != '0 |-> candidate_reg != confirmed_reg)
        else $error("stable count set while candidate equals confirmed posture");

    // No accumulated sit time survives while nobody is present
    a_none_clear: assert property (@(posedge clk) disable iff (!rst_n)
        confirmed_reg == POSTURE_NONE |-> sit_cnt_reg == '0)
        else $error("sit counter nonzero with no confirmed presence");

    // Sit time is reported only when leaving a sit
    a_report_event: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && res_reported_reg != '0 |->
            res_event_reg == EV_STOOD_UP || res_event_reg == EV_LEFT_SIT)
        else $error("reported seconds on an event that does not leave a sit");

    // A sit event leaves the tracker seated with a counter already running
    a_sit_event: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (event_next == EV_SAT_DOWN || event_next == EV_ARRIVED_SIT) |=>
            confirmed_reg == POSTURE_SIT && sit_cnt_reg == DURATION_BITS'(1))
        else $error("sit event did not restart the sit counter");
`endif

endmodule : posture_debounce_tracker_unit
`default_nettype wire
